// ----- hdl/wrcam_pkg.sv -----
// Shared types and codes for the RTS/CTS/ACK MAC.
package wrcam_pkg;

  localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic [1:0] KIND_RTS  = 2'd0;
  localparam logic [1:0] KIND_CTS  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_ACK  = 2'd3;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_ACKED   = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_BCAST   = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;
  localparam logic [2:0] ST_DEFER   = 3'd5;
  localparam logic [2:0] ST_RTS_RT  = 3'd6;
  localparam logic [2:0] ST_DATA_RT = 3'd7;

  localparam logic [2:0] REG_RTS_THR   = 3'd0;
  localparam logic [2:0] REG_RTS_LIM   = 3'd1;
  localparam logic [2:0] REG_DATA_LIM  = 3'd2;
  localparam logic [2:0] REG_CTS_WAIT  = 3'd3;
  localparam logic [2:0] REG_ACK_WAIT  = 3'd4;
  localparam logic [2:0] REG_OWN_ADDR  = 3'd5;

  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_CTS   = 4'b0010,
    PH_ACK   = 4'b0100,
    PH_DEFER = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        phy_idle;
    logic [11:0] frame_size;
    logic [47:0] dest_addr;
    logic [15:0] rts_airtime_us;
    logic [15:0] data_airtime_us;
    logic [7:0]  rts_rate_code;
    logic [7:0]  data_rate_code;
    logic [1:0]  rx_kind;
    logic [47:0] rx_addr1;
    logic [47:0] rx_addr2;
    logic [7:0]  rx_rate_code;
  } in_word_t;

  typedef struct packed {
    logic        tx_start;
    logic [1:0]  tx_kind;
    logic [47:0] tx_addr;
    logic [7:0]  tx_rate_code;
    logic        deliver_up;
    logic [2:0]  status;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    in_word_t w;
    logic     a1_own;
    logic     a1_bcast;
    logic     dest_bcast;
  } cls_word_t;

endpackage

// ----- hdl/wrcam_front.sv -----
// Front end: input register stage that classifies address matches.
module wrcam_front import wrcam_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [47:0] own_address,
  output cls_word_t cls,
  output logic      cls_valid,
  input  logic      cls_ready
);
  cls_word_t cls_reg;
  logic      full;

  assign in_ready  = !full || cls_ready;
  assign cls       = cls_reg;
  assign cls_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // own_address must change only while idle, so the compare may be staged; the block does not enforce this
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cls_reg.w          <= in_word;
      cls_reg.a1_own     <= in_word.rx_addr1 == own_address;
      cls_reg.a1_bcast   <= in_word.rx_addr1 == BCAST_ADDR;
      cls_reg.dest_bcast <= in_word.dest_addr == BCAST_ADDR;
    end
  end
endmodule

// ----- hdl/wrcam_back.sv -----
// Back end: frame state, retry timer and result register.
module wrcam_back import wrcam_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cls_word_t   cls,
  input  logic        cls_valid,
  output logic        cls_ready,
  input  logic [11:0] rts_threshold,
  input  logic [3:0]  rts_retry_limit,
  input  logic [3:0]  data_retry_limit,
  input  logic [9:0]  cts_wait_us,
  input  logic [9:0]  ack_wait_us,
  output out_word_t   out_word,
  output logic        out_valid,
  input  logic        out_ready
);
  logic        frame_held, frame_held_next;
  logic [47:0] held_dest;
  logic        held_bcast;
  logic [11:0] held_size;
  logic [15:0] held_rts_air, held_data_air;
  logic [7:0]  held_rts_rate, held_data_rate;
  logic [4:0]  rts_tries, rts_tries_next, data_tries, data_tries_next;
  phase_t      phase, phase_next;
  logic [16:0] timer, timer_next;
  out_word_t   res, out_reg;
  logic        out_full;
  logic        take;

  // effective held frame (new request loads these same cycle)
  logic        load;
  logic [47:0] e_dest;
  logic        e_bcast;
  logic [11:0] e_size;
  logic [15:0] e_rts_air, e_data_air;
  logic [7:0]  e_rts_rate, e_data_rate;
  logic        use_rts, expired, is_rts_ph, over;
  logic [4:0]  tries_inc;
  logic [16:0] timer_dec;
  in_word_t    w;

  assign w         = cls.w;
  assign cls_ready = !out_full || out_ready;
  assign take      = cls_valid && cls_ready;
  assign out_word  = out_reg;
  assign out_valid = out_full;
  assign load      = w.mode == MODE_SEND && !frame_held;

  always_comb begin
    e_dest      = load ? w.dest_addr       : held_dest;
    e_bcast     = load ? cls.dest_bcast    : held_bcast;
    e_size      = load ? w.frame_size      : held_size;
    e_rts_air   = load ? w.rts_airtime_us  : held_rts_air;
    e_data_air  = load ? w.data_airtime_us : held_data_air;
    e_rts_rate  = load ? w.rts_rate_code   : held_rts_rate;
    e_data_rate = load ? w.data_rate_code  : held_data_rate;
    use_rts     = rts_threshold < e_size && !e_bcast;
    timer_dec   = (timer != 17'd0) ? timer - 17'd1 : 17'd0;
    expired     = timer_dec == 17'd0;
    is_rts_ph   = phase == PH_CTS;
    tries_inc   = is_rts_ph ? rts_tries : data_tries;
    if (tries_inc != 5'd31) tries_inc = tries_inc + 5'd1;
    over = is_rts_ph ? (tries_inc > {1'b0, rts_retry_limit})
                     : (tries_inc > {1'b0, data_retry_limit});
  end

  always_comb begin
    logic do_tx, do_data;
    do_tx           = 1'b0;
    do_data         = 1'b0;
    res             = '0;
    frame_held_next = frame_held;
    rts_tries_next  = rts_tries;
    data_tries_next = data_tries;
    phase_next      = phase;
    timer_next      = timer;
    case (w.mode)
      MODE_SEND: begin
        if (frame_held) begin
          res.status = ST_REFUSED;
        end else begin
          frame_held_next = 1'b1;
          rts_tries_next  = '0;
          data_tries_next = '0;
          if (w.phy_idle) begin
            do_tx = 1'b1;
          end else begin
            res.status = ST_DEFER;
            phase_next = PH_DEFER;
            timer_next = '0;
          end
        end
      end
      MODE_RX: begin
        case (w.rx_kind)
          KIND_RTS: begin
            if (cls.a1_own) begin
              res.tx_start = 1'b1; res.tx_kind = KIND_CTS;
              res.tx_addr = w.rx_addr2; res.tx_rate_code = w.rx_rate_code;
            end
          end
          KIND_CTS: begin
            if (cls.a1_own && frame_held && phase == PH_CTS) do_data = 1'b1;
          end
          KIND_DATA: begin
            if (cls.a1_bcast) begin
              res.deliver_up = 1'b1;
            end else if (cls.a1_own) begin
              res.deliver_up = 1'b1; res.tx_start = 1'b1; res.tx_kind = KIND_ACK;
              res.tx_addr = w.rx_addr2; res.tx_rate_code = w.rx_rate_code;
            end
          end
          default: begin
            if (cls.a1_own && frame_held && phase == PH_ACK) begin
              frame_held_next = 1'b0;
              phase_next = PH_NONE;
              timer_next = '0;
              res.status = ST_ACKED;
            end
          end
        endcase
      end
      MODE_TICK: begin
        if (!frame_held) begin
          phase_next = PH_NONE;
        end else if (phase == PH_DEFER) begin
          do_tx = w.phy_idle;
        end else if (phase == PH_CTS || phase == PH_ACK) begin
          timer_next = timer_dec;
          if (expired) begin
            if (is_rts_ph) rts_tries_next = tries_inc;
            else data_tries_next = tries_inc;
            if (over) begin
              frame_held_next = 1'b0;
              phase_next = PH_NONE;
              timer_next = '0;
              res.status = ST_DROPPED;
            end else begin
              res.status = is_rts_ph ? ST_RTS_RT : ST_DATA_RT;
              if (w.phy_idle) begin
                do_tx = 1'b1;
              end else begin
                phase_next = PH_DEFER;
                timer_next = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (do_tx && use_rts) begin
      res.tx_start = 1'b1; res.tx_kind = KIND_RTS;
      res.tx_addr = e_dest; res.tx_rate_code = e_rts_rate;
      phase_next = PH_CTS;
      timer_next = {1'b0, e_rts_air} + {7'd0, cts_wait_us};
    end else if (do_tx || do_data) begin
      res.tx_start = 1'b1; res.tx_kind = KIND_DATA;
      res.tx_addr = e_dest; res.tx_rate_code = e_data_rate;
      if (e_bcast) begin
        frame_held_next = 1'b0;
        phase_next = PH_NONE;
        timer_next = '0;
        res.status = ST_BCAST;
      end else begin
        phase_next = PH_ACK;
        timer_next = {1'b0, e_data_air} + {7'd0, ack_wait_us};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_held <= 1'b0;
      rts_tries  <= '0;
      data_tries <= '0;
      phase      <= PH_NONE;
      timer      <= '0;
      out_full   <= 1'b0;
      held_dest <= '0; held_bcast <= 1'b0; held_size <= '0;
      held_rts_air <= '0; held_data_air <= '0;
      held_rts_rate <= '0; held_data_rate <= '0;
    end else begin
      if (cls_ready) out_full <= cls_valid;
      if (take) begin
        frame_held <= frame_held_next;
        rts_tries  <= rts_tries_next;
        data_tries <= data_tries_next;
        phase      <= phase_next;
        timer      <= timer_next;
        if (load) begin
          held_dest <= e_dest; held_bcast <= e_bcast; held_size <= e_size;
          held_rts_air <= e_rts_air; held_data_air <= e_data_air;
          held_rts_rate <= e_rts_rate; held_data_rate <= e_data_rate;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_reg <= res;
  end

  a_idle_no_frame: assert property (@(posedge clk) disable iff (rst)
    !frame_held |-> (phase == PH_NONE || phase == PH_DEFER || phase == PH_CTS
                     || phase == PH_ACK))
    else $error("bad phase");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_ready) |=> $stable(out_reg))
    else $error("result changed while stalled");
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_reg.tx_start) |-> (out_reg.tx_addr == '0 && out_reg.tx_kind == '0))
    else $error("fields set without send");
endmodule

// ----- hdl/wifi_rts_cts_ack_mac_top.sv -----
// Top level of the RTS/CTS/ACK MAC: config registers, front, back.
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_word (in_word_t)
//  out     | out | out_valid / out_ready | out_word (out_word_t)
//  cfg     | in  | cfg_we                | cfg_index, cfg_data
// One item per cycle sustained while out_ready stays high; each item passes the classify stage and the result register.
// Frame state updates in the back end on each accepted item, so items follow back to back.
// Synchronous reset restores register defaults and clears the held frame.
// A stalled output holds both stages; the stall reaches in_ready once the front stage is full.
module wifi_rts_cts_ack_mac_top import wrcam_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    in_word,
  input  logic        in_valid,
  output logic        in_ready,
  output out_word_t   out_word,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  logic [11:0] rts_threshold;
  logic [3:0]  rts_retry_limit, data_retry_limit;
  logic [9:0]  cts_wait_us, ack_wait_us;
  logic [47:0] own_address;
  cls_word_t   cls;
  logic        cls_valid, cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rts_threshold <= 12'd1; rts_retry_limit <= 4'd3; data_retry_limit <= 4'd3;
      cts_wait_us <= 10'd112; ack_wait_us <= 10'd112; own_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RTS_THR:  rts_threshold    <= cfg_data[11:0];
        REG_RTS_LIM:  rts_retry_limit  <= cfg_data[3:0];
        REG_DATA_LIM: data_retry_limit <= cfg_data[3:0];
        REG_CTS_WAIT: cts_wait_us      <= cfg_data[9:0];
        REG_ACK_WAIT: ack_wait_us      <= cfg_data[9:0];
        REG_OWN_ADDR: own_address      <= cfg_data;
        default: ;
      endcase
    end
  end

  wrcam_front u_front (
    .clk, .rst, .in_word, .in_valid, .in_ready, .own_address,
    .cls, .cls_valid, .cls_ready
  );

  wrcam_back u_back (
    .clk, .rst, .cls, .cls_valid, .cls_ready, .rts_threshold,
    .rts_retry_limit, .data_retry_limit, .cts_wait_us, .ack_wait_us,
    .out_word, .out_valid, .out_ready
  );
endmodule
